[hdl/olir_pkg.sv]
package olir_pkg;

  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 6;
  localparam int STATUS_W = 2;
  localparam int CMP_W    = INDEX_W + 1;

  typedef logic [ACTION_W-1:0]       action_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [INDEX_W-1:0]        index_t;
  typedef logic [STATUS_W-1:0]       status_t;

  localparam action_t ACT_APPEND       = 3'd0;
  localparam action_t ACT_INSERT       = 3'd1;
  localparam action_t ACT_REMOVE_FIRST = 3'd2;
  localparam action_t ACT_REMOVE_AT    = 3'd3;
  localparam action_t ACT_CLEAR        = 3'd4;

  localparam status_t STAT_DONE = 2'd0;
  localparam status_t STAT_FULL = 2'd1;
  localparam status_t STAT_NONE = 2'd2;

endpackage

[hdl/olir_if.sv]
interface olir_in_if;
  import olir_pkg::*;

  logic    valid;
  logic    ready;
  action_t action;
  value_t  value;
  index_t  index;

  modport source (output valid, action, value, index, input ready);
  modport sink (input valid, action, value, index, output ready);
endinterface

interface olir_out_if;
  import olir_pkg::*;

  logic    valid;
  logic    ready;
  value_t  item_value;
  index_t  position;
  logic    last;
  logic    empty_res;
  status_t status;

  modport source (output valid, item_value, position, last, empty_res, status, input ready);
  modport sink (input valid, item_value, position, last, empty_res, status, output ready);
endinterface

[hdl/olir_ram.sv]
module olir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/ordered_list_insert_remove_core.sv]
// Bounded ordered list of signed 32-bit values, up to DEPTH entries.
// items (sink): one action per transfer: append, insert at index, remove
//   first, remove at index, clear. ready is high only while the core idles.
// results (source): after each action the whole list goes out front to
//   back, one transfer per entry, last set on the final one; an empty list
//   gives a single transfer with empty_res set. All results of an action
//   carry the same status (done, full and dropped, nothing removed).
// The entries live in a single-port-write, registered-read RAM that is the
// one shared unit: every shift step and every emitted entry goes through it.
// Steps per action: decode; an insert or remove that changes the list then
// moves each shifted entry by a RAM read and a RAM write, and ends with a
// final step; then each entry is emitted by a RAM read and an output load
// (an empty list gives its one result directly); a stalled receiver holds this.
// The output register lets the next action be taken while the final
// result still waits for the receiver.
// Reset empties the list at once; no clearing pass, stale RAM words are
// never used.
module ordered_list_insert_remove_core #(
  parameter int DEPTH = 16
) (
  input logic       clk,
  input logic       rst,
  olir_in_if.sink   items,
  olir_out_if.source results
);
  import olir_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_UP_RD = 3'd1;
  localparam logic [2:0] S_UP_WR = 3'd2;
  localparam logic [2:0] S_DN_RD = 3'd3;
  localparam logic [2:0] S_DN_WR = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]    state;
  logic [CW-1:0] count;
  logic [CW-1:0] k;
  logic [CW-1:0] pos;
  value_t        val;
  status_t       status;
  logic [CW-1:0] emit_idx;
  logic          rd_pend;
  logic [CW-1:0] pend_pos;
  logic          pend_last;

  logic          out_valid;
  value_t        out_value;
  index_t        out_pos;
  logic          out_last;
  logic          out_empty;
  status_t       out_status;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  value_t        ram_wdata;
  logic [AW-1:0] ram_raddr;
  value_t        ram_rdata;

  logic [CW-1:0]    k_dec;
  logic [CW-1:0]    k_inc;
  logic [CW-1:0]    emit_inc;
  logic [CMP_W-1:0] count_x;
  logic [CMP_W-1:0] idx_x;
  logic             full;
  logic             out_free;
  logic             out_load;
  logic             accept;

  assign k_dec    = k - CW'(1);
  assign k_inc    = k + CW'(1);
  assign emit_inc = emit_idx + CW'(1);
  assign count_x  = CMP_W'(count);
  assign idx_x    = CMP_W'(items.index);
  assign full     = (count == CW'(DEPTH));
  assign out_free = !out_valid || results.ready;
  assign out_load = (state == S_EMIT) && ((count == '0) ? out_free : rd_pend);
  assign accept   = items.valid && items.ready;

  assign items.ready        = (state == S_IDLE);
  assign results.valid      = out_valid;
  assign results.item_value = out_value;
  assign results.position   = out_pos;
  assign results.last       = out_last;
  assign results.empty_res  = out_empty;
  assign results.status     = out_status;

  olir_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = k[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = '0;
    case (state)
      S_UP_RD: begin
        if (k == pos) begin
          ram_we    = 1'b1;
          ram_wdata = val;
        end else begin
          ram_raddr = k_dec[AW-1:0];
        end
      end
      S_UP_WR: begin
        ram_we = 1'b1;
      end
      S_DN_RD: begin
        ram_raddr = k_inc[AW-1:0];
      end
      S_DN_WR: begin
        ram_we = 1'b1;
      end
      S_EMIT: begin
        ram_raddr = emit_idx[AW-1:0];
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            val      <= items.value;
            emit_idx <= '0;
            rd_pend  <= 1'b0;
            case (items.action)
              ACT_APPEND, ACT_INSERT: begin
                if (full) begin
                  status <= STAT_FULL;
                  state  <= S_EMIT;
                end else begin
                  status <= STAT_DONE;
                  k      <= count;
                  state  <= S_UP_RD;
                  if (items.action == ACT_INSERT && idx_x < count_x) begin
                    pos <= CW'(items.index);
                  end else begin
                    pos <= count;
                  end
                end
              end
              ACT_REMOVE_FIRST: begin
                if (count == '0) begin
                  status <= STAT_NONE;
                  state  <= S_EMIT;
                end else begin
                  status <= STAT_DONE;
                  k      <= '0;
                  state  <= S_DN_RD;
                end
              end
              ACT_REMOVE_AT: begin
                if (idx_x >= count_x) begin
                  status <= STAT_NONE;
                  state  <= S_EMIT;
                end else begin
                  status <= STAT_DONE;
                  k      <= CW'(items.index);
                  state  <= S_DN_RD;
                end
              end
              ACT_CLEAR: begin
                status <= STAT_DONE;
                count  <= '0;
                state  <= S_EMIT;
              end
              default: begin
                status <= STAT_DONE;
                state  <= S_EMIT;
              end
            endcase
          end
        end
        S_UP_RD: begin
          if (k == pos) begin
            count <= count + CW'(1);
            state <= S_EMIT;
          end else begin
            state <= S_UP_WR;
          end
        end
        S_UP_WR: begin
          k     <= k_dec;
          state <= S_UP_RD;
        end
        S_DN_RD: begin
          if (k_inc >= count) begin
            count <= count - CW'(1);
            state <= S_EMIT;
          end else begin
            state <= S_DN_WR;
          end
        end
        S_DN_WR: begin
          k     <= k_inc;
          state <= S_DN_RD;
        end
        S_EMIT: begin
          if (count == '0) begin
            if (out_free) begin
              out_value  <= '0;
              out_pos    <= '0;
              out_last   <= 1'b1;
              out_empty  <= 1'b1;
              out_status <= status;
              state      <= S_IDLE;
            end
          end else if (rd_pend) begin
            out_value  <= ram_rdata;
            out_pos    <= INDEX_W'(pend_pos);
            out_last   <= pend_last;
            out_empty  <= 1'b0;
            out_status <= status;
            rd_pend    <= 1'b0;
            if (pend_last) begin
              state <= S_IDLE;
            end
          end else if (out_free) begin
            rd_pend   <= 1'b1;
            pend_pos  <= emit_idx;
            pend_last <= (emit_inc == count);
            emit_idx  <= emit_inc;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !items.ready)
    else $error("ready while an action is in progress");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.empty_res |-> results.last && results.position == '0)
    else $error("empty result not marked last at front");

  a_load_into_free: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> !out_valid)
    else $error("read data arrives while output register holds a result");

endmodule

[sim/tb_ordered_list_insert_remove_core.sv]
module tb_ordered_list_insert_remove_core;
  timeunit 1ns;
  timeprecision 1ps;

  import olir_pkg::*;

  localparam int DEPTH        = 16;
  localparam int NUM_RANDOM   = 192;
  localparam int DRAIN_CYCLES = 4 * DEPTH + 8;
  localparam int NUM_DIR      = 17;

  localparam action_t ACT_UNUSED_LO = 3'd5;
  localparam action_t ACT_UNUSED_HI = 3'd7;

  typedef struct packed {
    value_t  item_value;
    index_t  position;
    logic    last;
    logic    empty_res;
    status_t status;
  } list_result_t;

  typedef struct packed {
    action_t    act;
    value_t     val;
    index_t     idx;
    logic [3:0] reps;
    logic       typed;
    status_t    st;
  } stim_row_t;

  stim_row_t dir_rows [NUM_DIR] = '{
    '{ACT_REMOVE_FIRST, 32'sd0,           6'd0,  4'd1,  1'b1, STAT_NONE},
    '{ACT_REMOVE_AT,    32'sd0,           6'd0,  4'd1,  1'b1, STAT_NONE},
    '{ACT_CLEAR,        32'sd0,           6'd0,  4'd1,  1'b1, STAT_DONE},
    '{ACT_INSERT,       32'sh8000_0000,   6'd63, 4'd1,  1'b1, STAT_DONE},
    '{ACT_APPEND,       32'sh7fff_ffff,   6'd0,  4'd1,  1'b1, STAT_DONE},
    '{ACT_INSERT,       32'shffff_ffff,   6'd0,  4'd1,  1'b1, STAT_DONE},
    '{ACT_INSERT,       32'sd0,           6'd1,  4'd1,  1'b1, STAT_DONE},
    '{ACT_REMOVE_AT,    32'sd0,           6'd63, 4'd1,  1'b1, STAT_NONE},
    '{ACT_UNUSED_LO,    32'sd0,           6'd0,  4'd1,  1'b1, STAT_DONE},
    '{ACT_UNUSED_HI,    32'sh1234_5678,   6'd63, 4'd1,  1'b1, STAT_DONE},
    '{ACT_APPEND,       32'sh0001_0000,   6'd0,  4'd12, 1'b1, STAT_DONE},
    '{ACT_APPEND,       32'sh5a5a_5a5a,   6'd0,  4'd1,  1'b1, STAT_FULL},
    '{ACT_INSERT,       32'sha5a5_a5a5,   6'd0,  4'd1,  1'b1, STAT_FULL},
    '{ACT_REMOVE_AT,    32'sd0,           6'd15, 4'd1,  1'b1, STAT_DONE},
    '{ACT_INSERT,       32'sh0bad_cafe,   6'd15, 4'd1,  1'b0, STAT_DONE},
    '{ACT_CLEAR,        32'sd0,           6'd0,  4'd1,  1'b1, STAT_DONE},
    '{ACT_REMOVE_FIRST, 32'sd0,           6'd0,  4'd1,  1'b1, STAT_NONE}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  olir_in_if  items ();
  olir_out_if results ();

  ordered_list_insert_remove_core #(
    .DEPTH(DEPTH)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .results (results)
  );

  value_t       held_entries[$];
  list_result_t pending_results[$];
  int           mismatch_count = 0;
  bit           quiet_src = 1'b0;
  bit           quiet_snk = 1'b0;

  always #5 clk = ~clk;

  function automatic int pick_stall();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Apply one action to the local copy of the list and queue the list dump it produces.
  task automatic apply_list_action(input action_t act, input value_t val, input index_t idx,
                                   input bit typed, input status_t typed_st);
    status_t      st;
    list_result_t r;
    int           len;
    st  = STAT_DONE;
    len = held_entries.size();
    case (act)
      ACT_APPEND, ACT_INSERT: begin
        if (len >= DEPTH) begin
          st = STAT_FULL;
        end else if (act == ACT_APPEND || int'(idx) >= len) begin
          held_entries.push_back(val);
        end else begin
          held_entries.insert(int'(idx), val);
        end
      end
      ACT_REMOVE_FIRST: begin
        if (len == 0) begin
          st = STAT_NONE;
        end else begin
          void'(held_entries.pop_front());
        end
      end
      ACT_REMOVE_AT: begin
        if (int'(idx) >= len) begin
          st = STAT_NONE;
        end else begin
          held_entries.delete(int'(idx));
        end
      end
      ACT_CLEAR: begin
        held_entries.delete();
      end
      default: begin
      end
    endcase
    if (typed) begin
      st = typed_st;
    end
    if (held_entries.size() == 0) begin
      r = '{item_value: '0, position: '0, last: 1'b1, empty_res: 1'b1, status: st};
      pending_results.push_back(r);
    end else begin
      foreach (held_entries[k]) begin
        r.item_value = held_entries[k];
        r.position   = index_t'(k);
        r.last       = (k == held_entries.size() - 1);
        r.empty_res  = 1'b0;
        r.status     = st;
        pending_results.push_back(r);
      end
    end
  endtask

  task automatic send_item(input action_t act, input value_t val, input index_t idx,
                           input bit typed, input status_t st);
    items.valid  <= 1'b1;
    items.action <= act;
    items.value  <= val;
    items.index  <= idx;
    do @(posedge clk); while (!items.ready);
    apply_list_action(act, val, idx, typed, st);
  endtask

  task automatic hold_off(input int n);
    if (n > 0) begin
      items.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic note_mismatch(input string what, input list_result_t want,
                               input list_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t %s: expected value %0d pos %0d last %0b empty %0b status %0d", $realtime,
               what, want.item_value, want.position, want.last, want.empty_res, want.status);
      $display("    got value %0d pos %0d last %0b empty %0b status %0d",
               got.item_value, got.position, got.last, got.empty_res, got.status);
    end
  endtask

  always @(posedge clk) begin : result_monitor
    list_result_t got;
    list_result_t want;
    int           stall_left;
    int           cycle_count;
    if (!rst && results.valid && results.ready) begin
      got.item_value = results.item_value;
      got.position   = results.position;
      got.last       = results.last;
      got.empty_res  = results.empty_res;
      got.status     = results.status;
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected transfer", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.item_value !== want.item_value || got.position !== want.position ||
            got.last !== want.last || got.empty_res !== want.empty_res ||
            got.status !== want.status) begin
          note_mismatch("result mismatch", want, got);
        end
      end
    end
    cycle_count++;
    if (cycle_count % 300 == 0 && $urandom_range(0, 1) == 1) begin
      quiet_snk = ~quiet_snk;
    end
    if (rst) begin
      results.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      results.ready <= 1'b0;
    end else if (!quiet_snk && $urandom_range(0, 99) < 25) begin
      stall_left = pick_stall() - 1;
      results.ready <= 1'b0;
    end else begin
      results.ready <= 1'b1;
    end
  end

  initial begin
    #20ms;
    $display("[ordered_list_insert_remove_core] ERROR");
    $finish;
  end

  initial begin
    int      len;
    int      r;
    bit      grow_mode;
    action_t act;
    value_t  val;
    index_t  idx;
    items.valid   <= 1'b0;
    items.action  <= ACT_APPEND;
    items.value   <= '0;
    items.index   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      for (int k = 0; k < dir_rows[i].reps; k++) begin
        hold_off(($urandom_range(0, 99) < 50) ? 0 : pick_stall());
        send_item(dir_rows[i].act, dir_rows[i].val + value_t'(k), dir_rows[i].idx,
                  dir_rows[i].typed, dir_rows[i].st);
      end
    end

    grow_mode = 1'b1;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      len = held_entries.size();
      if (len == 0) begin
        grow_mode = 1'b1;
      end else if (len == DEPTH && $urandom_range(0, 2) == 0) begin
        grow_mode = 1'b0;
      end
      r = $urandom_range(0, 99);
      if (grow_mode) begin
        act = (r < 35) ? ACT_APPEND : (r < 65) ? ACT_INSERT : (r < 75) ? ACT_REMOVE_FIRST :
              (r < 89) ? ACT_REMOVE_AT : (r < 93) ? ACT_CLEAR :
              action_t'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
      end else begin
        act = (r < 10) ? ACT_APPEND : (r < 20) ? ACT_INSERT : (r < 52) ? ACT_REMOVE_FIRST :
              (r < 88) ? ACT_REMOVE_AT : (r < 93) ? ACT_CLEAR :
              action_t'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
      end
      case ($urandom_range(0, 7))
        0:       val = 32'sh8000_0000;
        1:       val = 32'sh7fff_ffff;
        2:       val = value_t'($urandom_range(0, 2)) - 32'sd1;
        default: val = value_t'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0:       idx = index_t'($urandom_range(0, 63));
        1:       idx = index_t'($urandom_range(0, len));
        2:       idx = (len > 0) ? index_t'(len - 1) : '0;
        default: idx = index_t'($urandom_range(0, (len > 0) ? len - 1 : 0));
      endcase
      hold_off((quiet_src || $urandom_range(0, 99) < 55) ? 0 : pick_stall());
      send_item(act, val, idx, 1'b0, STAT_DONE);
      if (n % 40 == 39) begin
        quiet_src = ~quiet_src;
      end
    end
    items.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ordered_list_insert_remove_core] OK");
    end else begin
      $display("[ordered_list_insert_remove_core] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
hdl/olir_pkg.sv
hdl/olir_if.sv
hdl/olir_ram.sv
hdl/ordered_list_insert_remove_core.sv
sim/tb_ordered_list_insert_remove_core.sv
